>>> rtl/pwelf_pkg.sv
package pwelf_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MDIV,
    ST_MUL,
    ST_M2,
    ST_VDIV,
    ST_DONE
  } state_e;

  localparam int unsigned ValW  = 32;
  localparam int unsigned M2W   = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned DiffW = 33;

endpackage

>>> rtl/pwelf_div.sv
// restoring divider, one quotient bit per cycle
module pwelf_div import pwelf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [M2W-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic           busy_o,
  output logic [M2W-1:0] quot_o
);

  logic [M2W-1:0]  quot_q, quot_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [CntW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CntW-1:0], quot_q[M2W-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 7'(M2W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[M2W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[M2W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/per_head_welford_statistics.sv
// sequence in accumulate mode: read, mean divide, multiply, m2 update, variance divide, done;
// read mode runs read, variance divide, done; the variance divide is skipped when the count
// is at most one, and every divide when the address is out of range; one request at a time,
// as in_ready_o stays low until the result is taken; the 64-step serial divider sets the pace
// reset: after rst_ni releases, a clearing pass writes zero to every element and head entry,
// one per cycle, with in_ready_o low meanwhile
module per_head_welford_statistics import pwelf_pkg::*; #(
  parameter int unsigned LAYERS   = 64,
  parameter int unsigned HEADS    = 64,
  parameter int unsigned HEAD_DIM = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [5:0]             layer_i,
  input  logic [5:0]             head_i,
  input  logic [6:0]             dim_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] mean_o,
  output logic [M2W-1:0]         variance_o,
  output logic [CntW-1:0]        count_o
);

  localparam int unsigned NHeads = LAYERS * HEADS;
  localparam int unsigned NElems = NHeads * HEAD_DIM;
  localparam int unsigned HW = (NHeads > 1) ? $clog2(NHeads) : 1;
  localparam int unsigned EW = (NElems > 1) ? $clog2(NElems) : 1;
  localparam int unsigned DW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;

  logic [ValW-1:0] mean_mem [NElems];
  logic [M2W-1:0]  m2_mem   [NElems];
  logic [CntW-1:0] cnt_mem  [NHeads];

  state_e state_q, state_d;
  logic [EW:0]  clr_q, clr_d;
  logic         mode_q, dim0_q, oor_q;
  logic [HW-1:0] hidx_q;
  logic [EW-1:0] eidx_q;
  logic signed [ValW-1:0] value_q;
  logic [ValW-1:0] mean_rd_q, mean_new_q;
  logic [M2W-1:0]  m2_rd_q, prod_q;
  logic [CntW-1:0] cnt_rd_q, cnt_new_q;
  logic signed [DiffW-1:0] delta_q, delta2_q;
  logic         out_valid_q;
  logic signed [ValW-1:0] mean_out_q;
  logic [M2W-1:0]  var_out_q;
  logic [CntW-1:0] cnt_out_q;

  logic         div_start, div_busy;
  logic [M2W-1:0] div_dvd, div_quot;
  logic [CntW-1:0] div_dvs;

  logic accept;
  logic [HW+DW-1:0] eidx_full;
  logic [HW-1:0]    hidx_in;
  logic in_oor;

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign in_oor = (32'(layer_i) >= LAYERS) || (32'(head_i) >= HEADS) ||
                  (32'(dim_i) >= HEAD_DIM);
  assign hidx_in   = HW'(32'(layer_i) * HEADS + 32'(head_i));
  assign eidx_full = (HW+DW)'(32'(hidx_in) * HEAD_DIM + 32'(dim_i));

  pwelf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // count after this step, divisor for the mean
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] n_eff;
  logic signed [DiffW-1:0] delta_c;
  logic [M2W-1:0]  dmag;
  logic signed [DiffW:0] mean_sum;
  logic signed [DiffW-1:0] qs;
  logic [M2W:0] add_w;
  logic [M2W-1:0] m2_calc;
  logic write_en;
  logic out_fire;

  always_comb begin
    cnt_inc = (dim0_q && !mode_q && cnt_rd_q != '1) ? cnt_rd_q + CntW'(1) : cnt_rd_q;
    // read registers hold for the whole request
    delta_c = DiffW'(value_q) - DiffW'($signed(mean_rd_q));
    n_eff = (cnt_inc == '0) ? CntW'(1) : cnt_inc;
    dmag  = delta_c[DiffW-1] ? M2W'(-delta_c) : M2W'(delta_c);
    qs    = delta_q[DiffW-1] ? -DiffW'(div_quot) : DiffW'(div_quot);
    mean_sum = (DiffW+1)'($signed(mean_rd_q)) + (DiffW+1)'(qs);
    add_w = {1'b0, m2_rd_q} + {1'b0, prod_q};
    if (delta_q == '0 || delta2_q == '0 || (delta_q[DiffW-1] == delta2_q[DiffW-1]))
      m2_calc = add_w[M2W] ? '1 : add_w[M2W-1:0];
    else
      m2_calc = (m2_rd_q < prod_q) ? '0 : m2_rd_q - prod_q;
  end

  assign out_fire = out_valid_q && out_ready_i;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    write_en  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (EW+1)'(NElems - 1)) state_d = ST_IDLE;
      end
      ST_IDLE:  if (accept) state_d = ST_READ;
      ST_READ: begin
        if (oor_q || mode_q) begin
          state_d = ST_VDIV;
          div_dvd = m2_rd_q;
          div_dvs = cnt_rd_q - CntW'(1);
          div_start = !oor_q && (cnt_rd_q > CntW'(1));
        end else begin
          state_d   = ST_MDIV;
          div_start = 1'b1;
          div_dvd   = dmag;
          div_dvs   = n_eff;
        end
      end
      ST_MDIV:  if (!div_busy) state_d = ST_MUL;
      ST_MUL:   state_d = ST_M2;
      ST_M2: begin
        write_en  = 1'b1;
        state_d   = ST_VDIV;
        div_dvd   = m2_calc;
        div_dvs   = cnt_new_q - CntW'(1);
        div_start = cnt_new_q > CntW'(1);
      end
      ST_VDIV:  if (!div_busy) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == ST_DONE) out_valid_q <= 1'b1;
      else if (out_fire)      out_valid_q <= 1'b0;
    end
  end

  // memories: read into registers at accept, ready in the next cycle, write back at the m2 stage
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mean_mem[clr_q[EW-1:0]] <= '0;
      m2_mem[clr_q[EW-1:0]]   <= '0;
      if (clr_q < (EW+1)'(NHeads)) cnt_mem[clr_q[HW-1:0]] <= '0;
    end else if (write_en) begin
      mean_mem[eidx_q] <= mean_new_q;
      m2_mem[eidx_q]   <= m2_calc;
      cnt_mem[hidx_q]  <= cnt_new_q;
    end
    if (accept) begin
      mean_rd_q <= mean_mem[EW'(eidx_full)];
      m2_rd_q   <= m2_mem[EW'(eidx_full)];
      cnt_rd_q  <= cnt_mem[hidx_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      dim0_q  <= (dim_i == '0);
      oor_q   <= in_oor;
      hidx_q  <= hidx_in;
      eidx_q  <= EW'(eidx_full);
      value_q <= value_i;
    end
    unique case (state_q)
      ST_READ: begin
        cnt_new_q  <= cnt_inc;
        delta_q    <= delta_c;
        mean_new_q <= mean_rd_q;
      end
      ST_MDIV: begin
        if (!div_busy) begin
          mean_new_q <= mean_sum[ValW-1:0];
          delta2_q   <= DiffW'(value_q) - DiffW'($signed(mean_sum[ValW-1:0]));
        end
      end
      ST_MUL: begin
        prod_q <= M2W'(dmag[DiffW-1:0]) *
                  M2W'(delta2_q[DiffW-1] ? -delta2_q : delta2_q);
      end
      default: ;
    endcase
    if (state_q == ST_DONE) begin
      if (oor_q) begin
        mean_out_q <= '0;
        var_out_q  <= '0;
        cnt_out_q  <= '0;
      end else begin
        mean_out_q <= mean_new_q;
        var_out_q  <= (cnt_new_q > CntW'(1)) ? div_quot : '0;
        cnt_out_q  <= cnt_new_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_out_q;
  assign variance_o  = var_out_q;
  assign count_o     = cnt_out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_IDLE)) else $error("request accepted while busy");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> out_valid_q) else $error("result lost");
  a_no_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_en |-> (state_q != ST_CLEAR)) else $error("write during clear");

endmodule
